// ----- hw/rtl/sacl_pkg.sv -----
// Shared constants, types and helpers for the set-associative LRU cache.
package sacl_pkg;

  localparam int NUM_WAYS    = 16;
  localparam int SET_BITS    = 4;
  localparam int OFFSET_BITS = 7;
  localparam int ADDR_BITS   = 20;
  localparam int DATA_BITS   = 32;

  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int WPL_BITS  = OFFSET_BITS - 2;
  localparam int WPL       = 1 << WPL_BITS;
  localparam int MEM_BITS  = ADDR_BITS - 2;
  localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int NUM_ENT   = NUM_SETS * NUM_WAYS;
  localparam int ENT_BITS  = $clog2(NUM_ENT);
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WCNT_BITS = $clog2(NUM_WAYS + 1);
  localparam int LINE_BITS = ENT_BITS + WPL_BITS;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic load_wr;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic fill_step;
    logic hit_capture;
    logic resp_set;
  } sacl_ctl_t;

  typedef struct packed {
    logic       clear_last;
    logic [1:0] cmd;
    logic       scan_done;
    logic       hit;
    logic       fill_done;
    logic       out_free;
  } sacl_sts_t;

  function automatic logic [ENT_BITS-1:0] ent_idx(input logic [SET_BITS-1:0] s,
                                                  input logic [WAY_BITS-1:0] w);
    ent_idx = ENT_BITS'(ENT_BITS'(s) * ENT_BITS'(NUM_WAYS) + ENT_BITS'(w));
  endfunction

endpackage

// ----- hw/rtl/sacl_ctrl.sv -----
// Controller state machine for the set-associative LRU cache.
module sacl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sacl_pkg::sacl_sts_t sts,
  output sacl_pkg::sacl_ctl_t ctl
);
  import sacl_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_DECIDE   = 8'b0001_0000,
    S_FILL     = 8'b0010_0000,
    S_HITRD    = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.cmd == CMD_LOAD) begin
          ctl.load_wr = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.cmd == CMD_READ || sts.cmd == CMD_WRITE) begin
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        if (sts.cmd == CMD_READ) begin
          state_nxt = sts.hit ? S_HITRD : S_FILL;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (sts.fill_done) state_nxt = S_RESP;
      end
      S_HITRD: begin
        ctl.hit_capture = 1'b1;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.resp_set = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ----- hw/rtl/sacl_dpath.sv -----
// Datapath of the set-associative LRU cache: arrays, way scan, line fill, result register.
module sacl_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sacl_pkg::sacl_ctl_t                 ctl,
  output sacl_pkg::sacl_sts_t                 sts,
  input  logic [1:0]                          in_command,
  input  logic [sacl_pkg::ADDR_BITS-1:0]      in_address,
  input  logic [sacl_pkg::DATA_BITS-1:0]      in_write_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sacl_pkg::DATA_BITS-1:0]      out_read_data,
  output logic                                out_hit
);
  import sacl_pkg::*;

  // storage
  logic [DATA_BITS-1:0] bmem     [0:(1<<MEM_BITS)-1];
  logic [DATA_BITS-1:0] line_mem [0:(1<<LINE_BITS)-1];
  logic [TAG_BITS-1:0]  tag_mem  [0:NUM_ENT-1];
  logic [DATA_BITS-1:0] stamp_mem[0:NUM_ENT-1];
  logic [NUM_ENT-1:0]   valid_r;

  logic [1:0]           cmd_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [DATA_BITS-1:0] wdata_r;
  logic [DATA_BITS-1:0] clock_r;
  logic [MEM_BITS-1:0]  clr_cnt_r;

  logic [WCNT_BITS-1:0] wcnt_r;
  logic                 spend_r;
  logic [WAY_BITS-1:0]  pway_r;
  logic [TAG_BITS-1:0]  tag_q_r;
  logic [DATA_BITS-1:0] stamp_q_r;
  logic                 hit_found_r, inv_found_r;
  logic [WAY_BITS-1:0]  hit_way_r, inv_way_r, min_way_r;
  logic [DATA_BITS-1:0] min_stamp_r;

  logic [ENT_BITS-1:0]  vict_ent_r;
  logic [WPL_BITS:0]    fcnt_r;
  logic                 fpend_r;
  logic [WPL_BITS-1:0]  pk_r;
  logic [DATA_BITS-1:0] bm_q_r, line_q_r;

  logic [DATA_BITS-1:0] rdata_r;
  logic                 hit_r;
  logic                 out_valid_r;
  logic [DATA_BITS-1:0] out_data_r;
  logic                 out_hit_r;

  logic [MEM_BITS-1:0]  word;
  logic [SET_BITS-1:0]  set_idx;
  logic [TAG_BITS-1:0]  tag;
  logic [WPL_BITS-1:0]  wofs;
  logic [ENT_BITS-1:0]  scan_ent, hit_ent, vict_ent;
  logic [WAY_BITS-1:0]  vict_way;
  logic                 scan_issue, fill_issue;
  logic                 do_hit;

  assign word    = addr_r[ADDR_BITS-1:2];
  assign set_idx = addr_r[OFFSET_BITS +: SET_BITS];
  assign tag     = addr_r[ADDR_BITS-1 -: TAG_BITS];
  assign wofs    = addr_r[OFFSET_BITS-1:2];

  assign scan_issue = ctl.scan_step && (wcnt_r < WCNT_BITS'(NUM_WAYS));
  assign scan_ent   = ent_idx(set_idx, wcnt_r[WAY_BITS-1:0]);
  assign hit_ent    = ent_idx(set_idx, hit_way_r);
  assign vict_way   = inv_found_r ? inv_way_r : min_way_r;
  assign vict_ent   = ent_idx(set_idx, vict_way);
  assign fill_issue = ctl.fill_step && (fcnt_r < (WPL_BITS+1)'(WPL));
  assign do_hit     = ctl.decide && hit_found_r;

  // input capture and access clock
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r   <= '0;
      clr_cnt_r <= '0;
      valid_r   <= '0;
    end else begin
      if (ctl.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctl.decide && (hit_found_r || cmd_r == CMD_READ)) clock_r <= clock_r + 1'b1;
      if (ctl.decide && !hit_found_r && cmd_r == CMD_READ) valid_r[vict_ent] <= 1'b1;
    end
  end

  // backing memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      bmem[clr_cnt_r] <= '0;
    end else if (ctl.load_wr || (ctl.decide && cmd_r == CMD_WRITE)) begin
      bmem[word] <= wdata_r;
    end
    if (fill_issue) begin
      bm_q_r <= bmem[{word[MEM_BITS-1:WPL_BITS], fcnt_r[WPL_BITS-1:0]}];
    end
  end

  // tag and stamp arrays
  always_ff @(posedge clk) begin
    if (ctl.decide && !hit_found_r && cmd_r == CMD_READ) begin
      tag_mem[vict_ent] <= tag;
    end
    if (scan_issue) begin
      tag_q_r <= tag_mem[scan_ent];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide && (hit_found_r || cmd_r == CMD_READ)) begin
      stamp_mem[hit_found_r ? hit_ent : vict_ent] <= clock_r;
    end
    if (scan_issue) begin
      stamp_q_r <= stamp_mem[scan_ent];
    end
  end

  // line data array
  always_ff @(posedge clk) begin
    if (fpend_r) begin
      line_mem[{vict_ent_r, pk_r}] <= bm_q_r;
    end else if (do_hit && cmd_r == CMD_WRITE) begin
      line_mem[{hit_ent, wofs}] <= wdata_r;
    end
    if (do_hit && cmd_r == CMD_READ) begin
      line_q_r <= line_mem[{hit_ent, wofs}];
    end
  end

  // way scan: one way issued per cycle, compared in the cycle after its issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spend_r <= 1'b0;
      wcnt_r  <= '0;
    end else if (ctl.scan_start) begin
      spend_r <= 1'b0;
      wcnt_r  <= '0;
    end else if (ctl.scan_step) begin
      spend_r <= scan_issue;
      if (scan_issue) wcnt_r <= wcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) pway_r <= wcnt_r[WAY_BITS-1:0];
    if (ctl.scan_start) begin
      hit_found_r <= 1'b0;
      inv_found_r <= 1'b0;
    end else if (spend_r) begin
      if (!hit_found_r && valid_r[ent_idx(set_idx, pway_r)] && tag_q_r == tag) begin
        hit_found_r <= 1'b1;
        hit_way_r   <= pway_r;
      end
      if (!inv_found_r && !valid_r[ent_idx(set_idx, pway_r)]) begin
        inv_found_r <= 1'b1;
        inv_way_r   <= pway_r;
      end
      // strict less-than keeps the lowest way on a tie
      if (pway_r == '0 || stamp_q_r < min_stamp_r) begin
        min_stamp_r <= stamp_q_r;
        min_way_r   <= pway_r;
      end
    end
  end

  // line fill from backing memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpend_r <= 1'b0;
      fcnt_r  <= '0;
    end else if (ctl.decide) begin
      fpend_r <= 1'b0;
      fcnt_r  <= '0;
    end else if (ctl.fill_step) begin
      fpend_r <= fill_issue;
      if (fill_issue) fcnt_r <= fcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_issue) pk_r <= fcnt_r[WPL_BITS-1:0];
    if (ctl.decide) vict_ent_r <= vict_ent;
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      rdata_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (do_hit) hit_r <= 1'b1;
      if (ctl.hit_capture) rdata_r <= line_q_r;
      if (fpend_r && pk_r == wofs) rdata_r <= bm_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.resp_set) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp_set) begin
      out_data_r <= rdata_r;
      out_hit_r  <= hit_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_hit       = out_hit_r;

  assign sts.clear_last = (clr_cnt_r == {MEM_BITS{1'b1}});
  assign sts.cmd        = cmd_r;
  assign sts.scan_done  = spend_r && (pway_r == WAY_BITS'(NUM_WAYS - 1));
  assign sts.hit        = hit_found_r;
  assign sts.fill_done  = fpend_r && (pk_r == WPL_BITS'(WPL - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ----- hw/rtl/set_assoc_cache_lru.sv -----
// One item at a time; the way scan reads one tag/stamp per cycle and a miss copies the line
// one backing memory word per cycle. An item also waits while a stalled result blocks the output.
// Reset (sync, active low) clears valid bits and the access clock, then sweeps the backing
// memory to zero one word per cycle while in_stall is held high.
// Top level of the set-associative write-through LRU cache.
module set_assoc_cache_lru (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [sacl_pkg::ADDR_BITS-1:0] in_address,
  input  logic [sacl_pkg::DATA_BITS-1:0] in_write_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sacl_pkg::DATA_BITS-1:0] out_read_data,
  output logic                           out_hit
);
  import sacl_pkg::*;

  sacl_ctl_t ctl;
  sacl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  sacl_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_hit       (out_hit)
  );

endmodule

// ----- hw/rtl/sacl_checker.sv -----
// Port-level checks for the set-associative LRU cache, bound to the top level.
module sacl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [1:0]                     in_command,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [sacl_pkg::DATA_BITS-1:0] out_read_data,
  input logic                           out_hit
);
  import sacl_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_hit))
    else $error("stalled result changed");

  // reset starts the clearing sweep: nothing accepted straight after
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("block not busy after reset");

  // one item in flight: busy after each input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a load with the output side empty never reports a hit or data
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_LOAD && !out_valid |=> ##2 out_valid &&
    !out_hit && out_read_data == '0)
    else $error("load result not zero");

endmodule

bind set_assoc_cache_lru sacl_checker u_sacl_checker (.*);
